[rtl/core/ihm_pkg.sv]
// ----------------------------------------------------------------------------
// ihm_pkg
// Shared types, sizes and helpers for the integer-key hash map: bucket and
// way geometry, the bucket row layout, command codes and the controller
// states.
// ----------------------------------------------------------------------------
`default_nettype none

package ihm_pkg;

    // Map geometry
    localparam int NUM_BUCKETS = 16;
    localparam int BUCKET_WAYS = 4;
    localparam int TOTAL_SLOTS = NUM_BUCKETS * BUCKET_WAYS;

    localparam int BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int WAY_W = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;

    // Field widths
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CMD_W   = 2;
    localparam int COUNT_W = 7;

    // Stream widths: input data {value_in, key}, output data padded to bytes
    localparam int IN_DATA_W  = KEY_W + VAL_W;
    localparam int OUT_RAW_W  = 1 + VAL_W + 1 + COUNT_W;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    // Controller states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // One way of a bucket row
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [KEY_W-1:0] key;
    } slot_t;

    // One bucket row as stored in the RAM
    typedef slot_t [BUCKET_WAYS-1:0] row_t;

    localparam int ROW_W = BUCKET_WAYS * (KEY_W + VAL_W);

    // Result of the way search over one bucket
    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] hit_way;
        logic             free;
        logic [WAY_W-1:0] free_way;
    } match_t;

    // Bucket of a key: magnitude modulo the bucket count
    function automatic logic [BKT_W-1:0] bucket_of(input logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] mag;
        mag = key[KEY_W-1] ? (KEY_W'(0) - key) : key;
        return BKT_W'(mag % NUM_BUCKETS);
    endfunction

endpackage

`default_nettype wire

[rtl/core/ihm_ram.sv]
// ----------------------------------------------------------------------------
// ihm_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is requested.
// ----------------------------------------------------------------------------
`default_nettype none

module ihm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                              clk,
    input  wire logic                              we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                  wr_data,
    input  wire logic                              rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output      logic [WIDTH-1:0]                  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/ihm_match.sv]
// ----------------------------------------------------------------------------
// ihm_match
// Way search over one bucket row: finds the lowest valid way whose key
// equals the probe key and the lowest free way.
// ----------------------------------------------------------------------------
`default_nettype none

module ihm_match
    import ihm_pkg::*;
(
    input  wire row_t                   row,
    input  wire logic [BUCKET_WAYS-1:0] valid,
    input  wire logic [KEY_W-1:0]       key,
    output      match_t                 result
);

    logic [BUCKET_WAYS-1:0] eq;

    // Compare every way at once
    always_comb
    begin
        for (int w = 0; w < BUCKET_WAYS; w++)
        begin
            eq[w] = valid[w] && (row[w].key == key);
        end
    end

    // Pick the lowest matching and the lowest free way
    always_comb
    begin
        result = '0;
        for (int w = BUCKET_WAYS - 1; w >= 0; w--)
        begin
            if (eq[w])
            begin
                result.hit     = 1'b1;
                result.hit_way = WAY_W'(w);
            end
            if (!valid[w])
            begin
                result.free     = 1'b1;
                result.free_way = WAY_W'(w);
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/int_key_hash_map.sv]
// ----------------------------------------------------------------------------
// int_key_hash_map
// Key-value map with signed 32-bit keys, bucketed by |key| modulo the bucket
// count, with a fixed number of ways per bucket held in one RAM row.
// ----------------------------------------------------------------------------
// Flow: an accepted command beat starts the bucket row read and moves the
//   controller to ST_EXEC, where the compare and write-back are done and the
//   result beat is registered onto m_tdata; a stalled result beat holds off
//   ST_EXEC. A new command is taken only in ST_IDLE, after the previous one
//   has written its bucket row back to the single RAM.
// Reset: rst_n asynchronous, active low; clears valid bits, count and control
//   at once, no clearing pass. RAM contents are not reset.
`default_nettype none

module int_key_hash_map
    import ihm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Command side
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] key, [63:32] value_in
    input  wire logic [CMD_W-1:0]      s_tuser,   // [1:0] command
    // Result side
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    output      logic [OUT_DATA_W-1:0] m_tdata    // [0] found, [32:1] value_out,
                                                  // [33] full_res,
                                                  // [40:34] entry_count, rest 0
);

    state_t state_reg, state_next;

    logic accept;
    logic exec_fire;

    cmd_t             cmd_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;
    logic [BKT_W-1:0] bkt_reg;
    logic [BKT_W-1:0] rd_bkt;

    row_t   row_rd;
    row_t   row_wr;
    logic   row_we;
    match_t match;

    logic [NUM_BUCKETS-1:0][BUCKET_WAYS-1:0] valid_reg, valid_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic             out_valid_reg, out_valid_next;
    logic             found_reg, found_next;
    logic [VAL_W-1:0] value_out_reg, value_out_next;
    logic             full_reg, full_next;

    // Handshake and controller outputs
    always_comb
    begin
        s_tready  = (state_reg == ST_IDLE);
        exec_fire = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);
    end

    assign accept = s_tvalid && s_tready;
    assign rd_bkt = bucket_of(s_tdata[KEY_W-1:0]);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Capture the command beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_t'(s_tuser);
            key_reg <= s_tdata[KEY_W-1:0];
            val_reg <= s_tdata[IN_DATA_W-1:KEY_W];
            bkt_reg <= rd_bkt;
        end
    end

    // Bucket row storage
    ihm_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_BUCKETS)
    ) u_row_ram (
        .clk     (clk),
        .we      (row_we),
        .wr_addr (bkt_reg),
        .wr_data (row_wr),
        .rd_en   (accept),
        .rd_addr (rd_bkt),
        .rd_data (row_rd)
    );

    // Search the bucket
    ihm_match u_match (
        .row    (row_rd),
        .valid  (valid_reg[bkt_reg]),
        .key    (key_reg),
        .result (match)
    );

    // Modify the row, valid bits, count and result
    always_comb
    begin
        row_wr         = row_rd;
        row_we         = 1'b0;
        valid_next     = valid_reg;
        count_next     = count_reg;
        found_next     = found_reg;
        value_out_next = value_out_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg && !m_tready;

        if (exec_fire)
        begin
            out_valid_next = 1'b1;
            found_next     = 1'b0;
            value_out_next = '0;
            full_next      = 1'b0;
            case (cmd_reg)
                CMD_INSERT:
                begin
                    if (match.hit)
                    begin
                        row_wr[match.hit_way].value = val_reg;
                        row_we     = 1'b1;
                        found_next = 1'b1;
                    end
                    else if (match.free)
                    begin
                        row_wr[match.free_way].key   = key_reg;
                        row_wr[match.free_way].value = val_reg;
                        row_we = 1'b1;
                        valid_next[bkt_reg][match.free_way] = 1'b1;
                        count_next = count_reg + COUNT_W'(1);
                    end
                    else
                    begin
                        full_next = 1'b1;
                    end
                end
                CMD_LOOKUP:
                begin
                    if (match.hit)
                    begin
                        found_next     = 1'b1;
                        value_out_next = row_rd[match.hit_way].value;
                    end
                end
                CMD_REMOVE:
                begin
                    if (match.hit)
                    begin
                        found_next     = 1'b1;
                        value_out_next = row_rd[match.hit_way].value;
                        valid_next[bkt_reg][match.hit_way] = 1'b0;
                        count_next = count_reg - COUNT_W'(1);
                    end
                end
                default:
                begin
                    valid_next = '0;
                    count_next = '0;
                end
            endcase
        end
    end

    // Valid bits, count and output control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        found_reg     <= found_next;
        value_out_reg <= value_out_next;
        full_reg      <= full_next;
    end

    // Drive the result beat; the count holds while the beat waits
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'({count_reg, full_reg, value_out_reg, found_reg});

    // Checks
    a_count_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        COUNT_W'($countones(valid_reg)) == count_reg)
        else $error("entry count differs from number of valid slots");

    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EXEC) && !s_tready)
        else $error("new command taken while one is in flight");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_fire && (cmd_reg == CMD_CLEAR)) |=> (valid_reg == '0) && (count_reg == '0))
        else $error("clear left entries behind");

    a_replace_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_fire && (cmd_reg == CMD_INSERT) && match.hit) |=> $stable(count_reg))
        else $error("replacing insert changed the count");

    a_found_full_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(found_reg && full_reg))
        else $error("result flags both found and full");

endmodule

`default_nettype wire
